[rtl/brme_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types of the byte register machine execute unit.
package brme_pkg;

    localparam int REG_DEPTH_DEF = 32;
    localparam int RAM_DEPTH_DEF = 256;

    localparam int BYTE_W      = 8;
    localparam int ST_W        = 2;
    localparam int REG_COUNT_W = 6;
    localparam int MEM_LIM_W   = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;

    localparam logic [REG_COUNT_W-1:0] REG_COUNT_RST = 6'd32;
    localparam logic [MEM_LIM_W-1:0]   MEM_LIM_RST   = 9'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_LIM   = 1'd1;

    localparam logic [BYTE_W-1:0] OP_AND   = 8'd0;
    localparam logic [BYTE_W-1:0] OP_OR    = 8'd1;
    localparam logic [BYTE_W-1:0] OP_ADD   = 8'd2;
    localparam logic [BYTE_W-1:0] OP_MUL   = 8'd3;
    localparam logic [BYTE_W-1:0] OP_XOR   = 8'd4;
    localparam logic [BYTE_W-1:0] OP_EMIT  = 8'd5;
    localparam logic [BYTE_W-1:0] OP_SLEEP = 8'd6;
    localparam logic [BYTE_W-1:0] OP_LOAD  = 8'd7;
    localparam logic [BYTE_W-1:0] OP_STORE = 8'd8;
    localparam logic [BYTE_W-1:0] OP_BNE   = 8'd9;
    localparam logic [BYTE_W-1:0] OP_LDI   = 8'd10;
    localparam logic [BYTE_W-1:0] OP_STI   = 8'd11;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_OP  = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_REG = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD_RAM = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              sleep_valid;
        logic [BYTE_W-1:0] sleep_seconds;
        logic              branch_taken;
        logic [BYTE_W-1:0] branch_target;
    } result_t;

    typedef struct packed {
        logic              reg_we;
        logic              is_load;
        logic              ram_we;
        logic [BYTE_W-1:0] ram_addr;
        logic [BYTE_W-1:0] ram_wdata;
        logic [BYTE_W-1:0] reg_wdata;
    } exec_ctl_t;

endpackage

[rtl/brme_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
module brme_ram
    #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
    )
    (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/brme_exec.sv]
`timescale 1ns / 1ps
// Execute stage: operation, status checks, write-back control and result fields.
module brme_exec
    import brme_pkg::*;
    #(
    parameter int RAM_DEPTH = RAM_DEPTH_DEF
    )
    (
    input  logic [BYTE_W-1:0]    op,
    input  logic [BYTE_W-1:0]    imm,
    input  logic [BYTE_W-1:0]    target,
    input  logic [BYTE_W-1:0]    x,
    input  logic [BYTE_W-1:0]    y,
    input  logic                 bad_idx,
    input  logic [MEM_LIM_W-1:0] mem_lim,
    output result_t              res,
    output exec_ctl_t            ctl
    );

    localparam logic [MEM_LIM_W-1:0] RAM_LIM = MEM_LIM_W'(RAM_DEPTH);

    logic [2*BYTE_W-1:0] prod;
    logic [BYTE_W-1:0]   alu;
    logic [BYTE_W-1:0]   addr;
    logic [ST_W-1:0]     st;
    logic                need_ram;
    logic                addr_ok;
    logic                ok;
    logic                is_alu;

    assign prod     = x * y;
    assign is_alu   = (op <= OP_XOR);
    assign need_ram = (op == OP_LOAD) || (op == OP_STORE) || (op == OP_STI);
    assign addr     = (op == OP_STORE) ? y : x;
    assign addr_ok  = ({1'b0, addr} < mem_lim) && ({1'b0, addr} < RAM_LIM);

    always_comb
    begin
        case (op)
            OP_AND:  alu = x & y;
            OP_OR:   alu = x | y;
            OP_ADD:  alu = x + y;
            OP_MUL:  alu = prod[BYTE_W-1:0];
            default: alu = x ^ y;
        endcase
    end

    always_comb
    begin
        if (op > OP_STI)
        begin
            st = ST_BAD_OP;
        end
        else if (bad_idx)
        begin
            st = ST_BAD_REG;
        end
        else if (need_ram && !addr_ok)
        begin
            st = ST_BAD_RAM;
        end
        else
        begin
            st = ST_OK;
        end
    end

    assign ok = (st == ST_OK);

    always_comb
    begin
        res               = '0;
        res.status        = st;
        res.out_valid     = ok && (op == OP_EMIT);
        res.out_byte      = (ok && (op == OP_EMIT)) ? x : '0;
        res.sleep_valid   = ok && (op == OP_SLEEP);
        res.sleep_seconds = (ok && (op == OP_SLEEP)) ? x : '0;
        res.branch_taken  = ok && (op == OP_BNE) && (x != y);
        res.branch_target = (ok && (op == OP_BNE) && (x != y)) ? target : '0;
    end

    assign ctl.reg_we    = ok && (is_alu || (op == OP_LDI) || (op == OP_LOAD));
    assign ctl.is_load   = (op == OP_LOAD);
    assign ctl.ram_we    = ok && ((op == OP_STORE) || (op == OP_STI));
    assign ctl.ram_addr  = addr;
    assign ctl.ram_wdata = (op == OP_STORE) ? x : imm;
    assign ctl.reg_wdata = (op == OP_LDI) ? imm : alu;

endmodule

[rtl/byte_register_machine_execute.sv]
`timescale 1ns / 1ps
// Top level of the byte register machine execute unit.
//
// Instructions enter on item_valid/item_ready, one transaction per instruction
// (opcode and three operand bytes). Each instruction yields exactly one result
// transaction on result_valid/result_ready with status, emit, sleep and branch
// fields. Configuration (register count, RAM size limit) is written through
// cfg_we, cfg_index and cfg_data; the user must write it only while the unit is
// idle; the block itself does not enforce this. An instruction passes the register
// file read, then execute and data memory read, then the output register, before
// result_valid rises. Throughput is one instruction per cycle while the output is
// not stalled; a load reads the register file and then the data memory in the
// following stage, and forwarding from the two later stages keeps back-to-back
// dependent instructions correct without stalls.
// Reset sets the register count to 32, the RAM size limit to 256 and clears both
// stores to zero via per-entry valid bits, so no clearing pass is needed and the
// unit is ready as soon as reset is released.
// When result_ready is held low with a result pending, the whole pipeline holds
// and item_ready drops; register file and data memory are not written while held.
module byte_register_machine_execute
    import brme_pkg::*;
    #(
    parameter int REG_DEPTH = REG_DEPTH_DEF,
    parameter int RAM_DEPTH = RAM_DEPTH_DEF
    )
    (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic [BYTE_W-1:0]     opcode,
    input  logic [BYTE_W-1:0]     first_operand,
    input  logic [BYTE_W-1:0]     second_operand,
    input  logic [BYTE_W-1:0]     third_operand,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [ST_W-1:0]       status,
    output logic                  out_valid,
    output logic [BYTE_W-1:0]     out_byte,
    output logic                  sleep_valid,
    output logic [BYTE_W-1:0]     sleep_seconds,
    output logic                  branch_taken,
    output logic [BYTE_W-1:0]     branch_target
    );

    localparam int RW = $clog2(REG_DEPTH);
    localparam int DW = $clog2(RAM_DEPTH);
    localparam logic [BYTE_W:0] REG_LIM = (BYTE_W+1)'(REG_DEPTH);

    logic [REG_COUNT_W-1:0] reg_count_reg;
    logic [MEM_LIM_W-1:0]   mem_lim_reg;

    logic adv;
    logic accept;
    logic commit;
    logic reg_commit;
    logic dm_commit;

    logic              is_alu;
    logic [BYTE_W-1:0] rd0_idx;
    logic [BYTE_W-1:0] rd1_idx;
    logic [RW-1:0]     ra0;
    logic [RW-1:0]     ra1;
    logic              ok_a;
    logic              ok_b;
    logic              ok_c;
    logic              bad_idx;

    logic [REG_DEPTH-1:0] rvld_reg;
    logic [RAM_DEPTH-1:0] dvld_reg;

    logic              p1_valid_reg;
    logic [BYTE_W-1:0] p1_op_reg;
    logic [BYTE_W-1:0] p1_b_reg;
    logic [BYTE_W-1:0] p1_c_reg;
    logic [RW-1:0]     p1_wa_reg;
    logic [RW-1:0]     p1_ra0_reg;
    logic [RW-1:0]     p1_ra1_reg;
    logic              p1_badidx_reg;
    logic              p1_v0_reg;
    logic              p1_v1_reg;
    logic              p1_f0_reg;
    logic              p1_f1_reg;
    logic [BYTE_W-1:0] p1_fd0_reg;
    logic [BYTE_W-1:0] p1_fd1_reg;

    logic              p2_valid_reg;
    result_t           p2_res_reg;
    exec_ctl_t         p2_ctl_reg;
    logic [RW-1:0]     p2_wa_reg;
    logic              p2_dv_reg;
    logic              p2_df_reg;
    logic [BYTE_W-1:0] p2_dd_reg;

    logic              res_valid_reg;
    result_t           res_reg;

    logic [BYTE_W-1:0] rq0;
    logic [BYTE_W-1:0] rq1;
    logic [BYTE_W-1:0] dq;
    logic [BYTE_W-1:0] x0;
    logic [BYTE_W-1:0] y0;
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] y;
    logic [BYTE_W-1:0] load_data;
    logic [BYTE_W-1:0] p2_reg_wdata;
    logic              p2_reg_write;
    result_t           ex_res;
    exec_ctl_t         ex_ctl;

    assign adv        = !res_valid_reg || result_ready;
    assign item_ready = adv;
    assign accept     = item_valid && adv;
    assign commit     = adv && p2_valid_reg;
    assign p2_reg_write = p2_valid_reg && p2_ctl_reg.reg_we;
    assign reg_commit = commit && p2_ctl_reg.reg_we;
    assign dm_commit  = commit && p2_ctl_reg.ram_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_count_reg <= REG_COUNT_RST;
            mem_lim_reg   <= MEM_LIM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REG_COUNT: reg_count_reg <= cfg_data[REG_COUNT_W-1:0];
                CFG_MEM_LIM:   mem_lim_reg   <= cfg_data[MEM_LIM_W-1:0];
                default:       reg_count_reg <= reg_count_reg;
            endcase
        end
    end

    assign is_alu  = (opcode <= OP_XOR);
    assign rd0_idx = (is_alu || (opcode == OP_LOAD)) ? second_operand : first_operand;
    assign rd1_idx = is_alu ? third_operand : second_operand;
    assign ra0     = rd0_idx[RW-1:0];
    assign ra1     = rd1_idx[RW-1:0];

    assign ok_a = ({1'b0, first_operand} < {3'b000, reg_count_reg})
                  && ({1'b0, first_operand} < REG_LIM);
    assign ok_b = ({1'b0, second_operand} < {3'b000, reg_count_reg})
                  && ({1'b0, second_operand} < REG_LIM);
    assign ok_c = ({1'b0, third_operand} < {3'b000, reg_count_reg})
                  && ({1'b0, third_operand} < REG_LIM);

    always_comb
    begin
        unique case (opcode) inside
            [OP_AND:OP_XOR]:           bad_idx = !(ok_a && ok_b && ok_c);
            OP_LOAD, OP_STORE, OP_BNE: bad_idx = !(ok_a && ok_b);
            default:                   bad_idx = !ok_a;
        endcase
    end

    brme_ram
        #(
        .WIDTH (BYTE_W),
        .DEPTH (REG_DEPTH)
        )
    u_rf0
        (
        .clk   (clk),
        .we    (reg_commit),
        .waddr (p2_wa_reg),
        .wdata (p2_reg_wdata),
        .re    (adv),
        .raddr (ra0),
        .rdata (rq0)
        );

    brme_ram
        #(
        .WIDTH (BYTE_W),
        .DEPTH (REG_DEPTH)
        )
    u_rf1
        (
        .clk   (clk),
        .we    (reg_commit),
        .waddr (p2_wa_reg),
        .wdata (p2_reg_wdata),
        .re    (adv),
        .raddr (ra1),
        .rdata (rq1)
        );

    brme_ram
        #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
        )
    u_dm
        (
        .clk   (clk),
        .we    (dm_commit),
        .waddr (p2_ctl_reg.ram_addr[DW-1:0]),
        .wdata (p2_ctl_reg.ram_wdata),
        .re    (adv),
        .raddr (ex_ctl.ram_addr[DW-1:0]),
        .rdata (dq)
        );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvld_reg <= '0;
            dvld_reg <= '0;
        end
        else
        begin
            if (reg_commit)
            begin
                rvld_reg[p2_wa_reg] <= 1'b1;
            end
            if (dm_commit)
            begin
                dvld_reg[p2_ctl_reg.ram_addr[DW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg  <= accept;
            p2_valid_reg  <= p1_valid_reg;
            res_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_op_reg     <= opcode;
            p1_b_reg      <= second_operand;
            p1_c_reg      <= third_operand;
            p1_wa_reg     <= first_operand[RW-1:0];
            p1_ra0_reg    <= ra0;
            p1_ra1_reg    <= ra1;
            p1_badidx_reg <= bad_idx;
            p1_v0_reg     <= rvld_reg[ra0];
            p1_v1_reg     <= rvld_reg[ra1];
            p1_f0_reg     <= p2_reg_write && (p2_wa_reg == ra0);
            p1_f1_reg     <= p2_reg_write && (p2_wa_reg == ra1);
            p1_fd0_reg    <= p2_reg_wdata;
            p1_fd1_reg    <= p2_reg_wdata;

            p2_res_reg    <= ex_res;
            p2_ctl_reg    <= ex_ctl;
            p2_wa_reg     <= p1_wa_reg;
            p2_dv_reg     <= dvld_reg[ex_ctl.ram_addr[DW-1:0]];
            p2_df_reg     <= p2_valid_reg && p2_ctl_reg.ram_we
                             && (p2_ctl_reg.ram_addr == ex_ctl.ram_addr);
            p2_dd_reg     <= p2_ctl_reg.ram_wdata;

            res_reg       <= p2_res_reg;
        end
    end

    assign x0 = p1_f0_reg ? p1_fd0_reg : (p1_v0_reg ? rq0 : '0);
    assign y0 = p1_f1_reg ? p1_fd1_reg : (p1_v1_reg ? rq1 : '0);
    assign x  = (p2_reg_write && (p2_wa_reg == p1_ra0_reg)) ? p2_reg_wdata : x0;
    assign y  = (p2_reg_write && (p2_wa_reg == p1_ra1_reg)) ? p2_reg_wdata : y0;

    assign load_data    = p2_df_reg ? p2_dd_reg : (p2_dv_reg ? dq : '0);
    assign p2_reg_wdata = p2_ctl_reg.is_load ? load_data : p2_ctl_reg.reg_wdata;

    brme_exec
        #(
        .RAM_DEPTH (RAM_DEPTH)
        )
    u_exec
        (
        .op       (p1_op_reg),
        .imm      (p1_b_reg),
        .target   (p1_c_reg),
        .x        (x),
        .y        (y),
        .bad_idx  (p1_badidx_reg),
        .mem_lim  (mem_lim_reg),
        .res      (ex_res),
        .ctl      (ex_ctl)
        );

    assign result_valid  = res_valid_reg;
    assign status        = res_reg.status;
    assign out_valid     = res_reg.out_valid;
    assign out_byte      = res_reg.out_byte;
    assign sleep_valid   = res_reg.sleep_valid;
    assign sleep_seconds = res_reg.sleep_seconds;
    assign branch_taken  = res_reg.branch_taken;
    assign branch_target = res_reg.branch_target;

`ifndef SYNTHESIS
    a_write_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg && (p2_ctl_reg.reg_we || p2_ctl_reg.ram_we)
        |-> p2_res_reg.status == ST_OK)
        else $error("state write on a failed instruction");

    a_single_store: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg |-> !(p2_ctl_reg.reg_we && p2_ctl_reg.ram_we))
        else $error("instruction writes both stores");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !result_ready
        |=> $stable(p1_valid_reg) && $stable(p2_valid_reg) && !$past(commit))
        else $error("pipeline moved while output stalled");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg
        |-> $onehot0({res_reg.out_valid, res_reg.sleep_valid, res_reg.branch_taken}))
        else $error("more than one result flag set");
`endif

endmodule
